/* src/fpmk_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpmk_pkg
// Shared types and constants of the fixed-priority (m,k)-firm scheduler.
// ----------------------------------------------------------------------------
package fpmk_pkg;

  localparam int unsigned MissLimitW = 2;
  localparam int unsigned TimeW      = 32;

  localparam logic       ModeLoad = 1'b0;
  localparam logic       ModeTick = 1'b1;
  localparam logic [1:0] MissLimitReset = 2'd1;

  typedef struct packed {
    logic        mode;
    logic [2:0]  task_slot;
    logic [11:0] exec_budget;
    logic [11:0] release_period;
    logic [11:0] relative_deadline;
    logic [15:0] first_release;
  } in_t;

  typedef struct packed {
    logic              cpu_busy;
    logic [2:0]        running_slot;
    logic              job_finished;
    logic              deadline_missed;
    logic              task_violating;
    logic [3:0]        violating_tasks;
    logic [TimeW-1:0]  tick_time;
  } out_t;

endpackage

/* src/fpmk_window.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpmk_window
// Miss window update: record met or missed in the current slot, advance the
// slot pointer and flag a window holding more misses than allowed.
// ----------------------------------------------------------------------------
module fpmk_window
  import fpmk_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = 3,
  localparam int unsigned SlotW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1,
  localparam int unsigned PcW   = $clog2(WINDOW_LEN + 1),
  localparam int unsigned CmpW  = (PcW > MissLimitW) ? PcW : MissLimitW
) (
  input  logic [WINDOW_LEN-1:0] window_i,
  input  logic [SlotW-1:0]      slot_i,
  input  logic                  miss_i,
  input  logic [MissLimitW-1:0] miss_limit_i,
  output logic [WINDOW_LEN-1:0] window_o,
  output logic [SlotW-1:0]      slot_o,
  output logic                  exceed_o
);

  logic [WINDOW_LEN-1:0] slot_bit;
  logic [PcW-1:0]        miss_cnt;

  assign slot_bit = WINDOW_LEN'(1) << slot_i;
  assign window_o = miss_i ? (window_i | slot_bit) : (window_i & ~slot_bit);
  assign slot_o   = (slot_i == SlotW'(WINDOW_LEN - 1)) ? '0 : SlotW'(slot_i + 1'b1);

  always_comb begin
    miss_cnt = '0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      miss_cnt = miss_cnt + PcW'(window_o[i]);
    end
  end

  assign exceed_o = CmpW'(miss_cnt) > CmpW'(miss_limit_i);

endmodule

/* src/fixed_priority_mk_firm_scheduler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_priority_mk_firm_scheduler
// Tick-driven preemptive fixed-priority scheduler with (m,k)-firm deadline
// monitoring. Task entries live in one synchronous task memory; valid bits and flags are registers.
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_ready_o   in_data_i  (in_t)
//   out       output     out_valid_o / out_ready_i out_data_o (out_t)
//   cfg       input      cfg_we_i                  cfg_wdata_i (miss_limit)
//
// A load transaction writes its memory entry directly when accepted.
// A tick transaction issues the first read when accepted, then scans the
// entries in priority order through the single memory read port, does a
// read-modify-write of the running entry in the update state and loads the
// output register in the output state; an idle tick skips the update state.
// Reset clears task valid bits, violation flags and time; no clearing pass.
// A stalled output holds the next tick in the output state; loads wait.
// ----------------------------------------------------------------------------
module fixed_priority_mk_firm_scheduler
  import fpmk_pkg::*;
#(
  parameter int unsigned NUM_TASKS  = 8,
  parameter int unsigned WINDOW_LEN = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_t                  out_data_o,
  input  logic                  cfg_we_i,
  input  logic [MissLimitW-1:0] cfg_wdata_i
);

  localparam int unsigned IdxW  = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int unsigned SlotW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int unsigned CntW  = $clog2(NUM_TASKS + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_TASKS - 1);

  typedef struct packed {
    logic [11:0]           budget;
    logic [11:0]           period;
    logic [11:0]           work;
    logic [TimeW-1:0]      nrel;
    logic [TimeW-1:0]      dl;
    logic [WINDOW_LEN-1:0] win;
    logic [SlotW-1:0]      wslot;
  } entry_t;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StUpdate,
    StOut
  } state_e;

  function automatic logic [TimeW-1:0] sat_add(logic [TimeW-1:0] a, logic [11:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + (TimeW + 1)'(b);
    return s[TimeW] ? '1 : s[TimeW-1:0];
  endfunction

  state_e                state_q;
  logic [TimeW-1:0]      now_q, t_q;
  logic [IdxW-1:0]       chk_q, run_q;
  logic [NUM_TASKS-1:0]  vld_q, flag_q;
  logic [CntW-1:0]       vcnt_q;
  logic [MissLimitW-1:0] miss_limit_q;
  entry_t                ent_q;
  out_t                  res_q, out_q;
  logic                  out_valid_q;

  entry_t                mem_q [NUM_TASKS];
  entry_t                rd_q;
  logic                  rd_vld_q;

  logic                  in_acc, tick_acc, load_acc, load_ok;
  logic [IdxW-1:0]       load_idx;
  logic                  rd_en, wr_en;
  logic [IdxW-1:0]       rd_addr, wr_addr;
  entry_t                wr_data, load_ent, upd_ent;
  logic                  eligible;
  logic [11:0]           work_dec;
  logic                  fin, miss, exceed, set_flag;
  logic [WINDOW_LEN-1:0] win_new;
  logic [SlotW-1:0]      wslot_new;
  logic [CntW-1:0]       vcnt_d;

  assign in_ready_o  = (state_q == StIdle);
  assign in_acc      = in_valid_i && in_ready_o;
  assign tick_acc    = in_acc && (in_data_i.mode == ModeTick);
  assign load_acc    = in_acc && (in_data_i.mode == ModeLoad);
  assign load_ok     = 32'(in_data_i.task_slot) < NUM_TASKS;
  assign load_idx    = IdxW'(in_data_i.task_slot);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign eligible = rd_vld_q && (rd_q.nrel <= t_q) && (rd_q.work != '0);

  assign rd_en   = tick_acc || ((state_q == StScan) && (chk_q != LastIdx));
  assign rd_addr = (state_q == StIdle) ? '0 : IdxW'(chk_q + IdxW'(1));

  fpmk_window #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_window (
    .window_i    (ent_q.win),
    .slot_i      (ent_q.wslot),
    .miss_i      (miss),
    .miss_limit_i(miss_limit_q),
    .window_o    (win_new),
    .slot_o      (wslot_new),
    .exceed_o    (exceed)
  );

  always_comb begin
    work_dec = ent_q.work - 12'd1;
    fin      = (work_dec == '0);
    miss     = t_q > ent_q.dl;
    set_flag = fin && exceed;
    upd_ent  = ent_q;
    if (fin) begin
      upd_ent.work  = ent_q.budget;
      upd_ent.nrel  = sat_add(ent_q.nrel, ent_q.period);
      upd_ent.dl    = sat_add(ent_q.dl, ent_q.period);
      upd_ent.win   = win_new;
      upd_ent.wslot = wslot_new;
    end else begin
      upd_ent.work  = work_dec;
    end
    vcnt_d = vcnt_q;
    if (set_flag && !flag_q[run_q]) begin
      vcnt_d = vcnt_q + CntW'(1);
    end
  end

  always_comb begin
    load_ent.budget = in_data_i.exec_budget;
    load_ent.period = in_data_i.release_period;
    load_ent.work   = in_data_i.exec_budget;
    load_ent.nrel   = TimeW'(in_data_i.first_release);
    load_ent.dl     = TimeW'(in_data_i.first_release) + TimeW'(in_data_i.relative_deadline);
    load_ent.win    = '0;
    load_ent.wslot  = '0;
  end

  assign wr_en   = (load_acc && load_ok) || (state_q == StUpdate);
  assign wr_addr = (state_q == StUpdate) ? run_q : load_idx;
  assign wr_data = (state_q == StUpdate) ? upd_ent : load_ent;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q     <= mem_q[rd_addr];
      rd_vld_q <= vld_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      now_q        <= '0;
      t_q          <= '0;
      chk_q        <= '0;
      run_q        <= '0;
      vld_q        <= '0;
      flag_q       <= '0;
      vcnt_q       <= '0;
      miss_limit_q <= MissLimitReset;
      ent_q        <= '0;
      res_q        <= '0;
      out_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        miss_limit_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_ready_i && (state_q != StOut)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (tick_acc) begin
            t_q     <= now_q;
            now_q   <= (now_q == '1) ? now_q : now_q + TimeW'(1);
            chk_q   <= '0;
            state_q <= StScan;
          end else if (load_acc && load_ok) begin
            vld_q[load_idx]  <= 1'b1;
            flag_q[load_idx] <= 1'b0;
            if (flag_q[load_idx]) begin
              vcnt_q <= vcnt_q - CntW'(1);
            end
          end
        end
        StScan: begin
          if (eligible) begin
            run_q   <= chk_q;
            ent_q   <= rd_q;
            state_q <= StUpdate;
          end else if (chk_q == LastIdx) begin
            res_q   <= {1'b0, 3'd0, 1'b0, 1'b0, 1'b0, 4'(vcnt_q), t_q};
            state_q <= StOut;
          end else begin
            chk_q <= IdxW'(chk_q + IdxW'(1));
          end
        end
        StUpdate: begin
          if (set_flag) begin
            flag_q[run_q] <= 1'b1;
          end
          vcnt_q                <= vcnt_d;
          res_q.cpu_busy        <= 1'b1;
          res_q.running_slot    <= 3'(run_q);
          res_q.job_finished    <= fin;
          res_q.deadline_missed <= fin && miss;
          res_q.task_violating  <= flag_q[run_q] || set_flag;
          res_q.violating_tasks <= 4'(vcnt_d);
          res_q.tick_time       <= t_q;
          state_q               <= StOut;
        end
        StOut: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  a_vcnt_matches_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vcnt_q == CntW'($countones(flag_q)))
    else $error("violation count out of step with flags");

  a_miss_needs_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.deadline_missed |-> out_data_o.job_finished)
    else $error("deadline miss reported without job completion");

  a_idle_result_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.cpu_busy |->
      out_data_o.running_slot == '0 && !out_data_o.job_finished &&
      !out_data_o.task_violating)
    else $error("idle tick carries task fields");

  a_tick_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc |=> state_q == StScan && t_q == $past(now_q))
    else $error("tick transaction did not start scan at current time");

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fixed-priority (m,k)-firm scheduler. A directed
// burst of loads and ticks is followed by random task sets run under several
// miss limits. Each accepted transaction updates a bit-accurate task-table
// model, and each tick result is checked field by field, in order.
// ----------------------------------------------------------------------------
module tb;
  import fpmk_pkg::*;

  localparam int unsigned NumTasks  = 8;
  localparam int unsigned WindowLen = 3;
  localparam int unsigned NumItems  = 950;
  localparam int unsigned NumPhases = 6;
  localparam int unsigned Settle    = 24;
  localparam int unsigned MaxCycles = 400000;
  localparam int unsigned MaxReport = 10;

  class tick_scoreboard;
    bit [1:0]           miss_limit;
    bit [31:0]          now_time;
    bit [11:0]          budget[NumTasks];
    bit [11:0]          period[NumTasks];
    bit [11:0]          work_left[NumTasks];
    bit [31:0]          next_rel[NumTasks];
    bit [31:0]          abs_dl[NumTasks];
    bit [WindowLen-1:0] window[NumTasks];
    int unsigned        win_ptr[NumTasks];
    bit                 viol[NumTasks];
    out_t               expected_ticks[$];
    int unsigned        errors;

    function new();
      miss_limit = MissLimitReset;
      now_time   = '0;
      errors     = 0;
      for (int i = 0; i < NumTasks; i++) begin
        budget[i]    = '0;
        period[i]    = '0;
        work_left[i] = '0;
        next_rel[i]  = '0;
        abs_dl[i]    = '0;
        window[i]    = '0;
        win_ptr[i]   = 0;
        viol[i]      = 1'b0;
      end
    endfunction

    function bit [31:0] sat_add(bit [31:0] a, bit [11:0] b);
      bit [32:0] s;
      s = 33'(a) + 33'(b);
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function string fmt(out_t r);
      return $sformatf("busy=%0d slot=%0d fin=%0d miss=%0d viol=%0d nviol=%0d t=%0d",
                       r.cpu_busy, r.running_slot, r.job_finished, r.deadline_missed,
                       r.task_violating, r.violating_tasks, r.tick_time);
    endfunction

    function void note_transaction(in_t item);
      out_t        res;
      bit          busy;
      int unsigned run;
      int unsigned s;
      int unsigned nviol;
      busy  = 1'b0;
      run   = 0;
      nviol = 0;
      if (item.mode == ModeLoad) begin
        s            = 32'(item.task_slot);
        budget[s]    = item.exec_budget;
        period[s]    = item.release_period;
        work_left[s] = item.exec_budget;
        next_rel[s]  = 32'(item.first_release);
        abs_dl[s]    = 32'(item.first_release) + 32'(item.relative_deadline);
        window[s]    = '0;
        win_ptr[s]   = 0;
        viol[s]      = 1'b0;
        return;
      end
      res           = '0;
      res.tick_time = now_time;
      for (int i = 0; i < NumTasks; i++) begin
        if (!busy && next_rel[i] <= now_time && work_left[i] != 0) begin
          busy = 1'b1;
          run  = i;
        end
      end
      if (busy) begin
        res.cpu_busy     = 1'b1;
        res.running_slot = 3'(run);
        work_left[run]--;
        if (work_left[run] == 0) begin
          res.job_finished              = 1'b1;
          res.deadline_missed           = now_time > abs_dl[run];
          window[run][win_ptr[run]]     = res.deadline_missed;
          win_ptr[run]                  = (win_ptr[run] + 1) % WindowLen;
          if ($countones(window[run]) > miss_limit) viol[run] = 1'b1;
          next_rel[run]  = sat_add(next_rel[run], period[run]);
          abs_dl[run]    = sat_add(abs_dl[run], period[run]);
          work_left[run] = budget[run];
        end
        res.task_violating = viol[run];
      end
      for (int i = 0; i < NumTasks; i++) nviol += 32'(viol[i]);
      res.violating_tasks = 4'(nviol);
      if (now_time != 32'hFFFF_FFFF) now_time++;
      expected_ticks.push_back(res);
    endfunction

    function void check_tick(out_t got);
      out_t want;
      if (expected_ticks.size() == 0) begin
        errors++;
        if (errors <= MaxReport) $display("unexpected tick result: %s", fmt(got));
        return;
      end
      want = expected_ticks.pop_front();
      if (got.cpu_busy        !== want.cpu_busy        ||
          got.running_slot    !== want.running_slot    ||
          got.job_finished    !== want.job_finished    ||
          got.deadline_missed !== want.deadline_missed ||
          got.task_violating  !== want.task_violating  ||
          got.violating_tasks !== want.violating_tasks ||
          got.tick_time       !== want.tick_time) begin
        errors++;
        if (errors <= MaxReport) begin
          $display("tick mismatch: expected %s", fmt(want));
          $display("               actual   %s", fmt(got));
        end
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_t                   in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_t                  out_data_o;
  logic                  cfg_we_i;
  logic [MissLimitW-1:0] cfg_wdata_i;

  tick_scoreboard book;
  bit             calm;
  int unsigned    items_sent;
  int unsigned    cycles;

  fixed_priority_mk_firm_scheduler uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= MaxCycles) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) book.check_tick(out_data_o);
  end

  initial begin
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (calm) begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end else if ($urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  function automatic in_t mk_load(int unsigned slot, int unsigned budget, int unsigned period,
                                  int unsigned rdl, int unsigned first);
    in_t item;
    item.mode              = ModeLoad;
    item.task_slot         = 3'(slot);
    item.exec_budget       = 12'(budget);
    item.release_period    = 12'(period);
    item.relative_deadline = 12'(rdl);
    item.first_release     = 16'(first);
    return item;
  endfunction

  function automatic in_t mk_tick();
    in_t         item;
    logic [63:0] raw;
    raw       = {$urandom, $urandom};
    item      = raw[$bits(in_t)-1:0];
    item.mode = ModeTick;
    return item;
  endfunction

  function automatic in_t mk_noise();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(in_t)-1:0];
  endfunction

  // short jobs released near the current time, so deadlines are hit and missed
  function automatic in_t mk_small_load();
    return mk_load($urandom_range(0, NumTasks - 1), $urandom_range(1, 4),
                   ($urandom_range(0, 29) == 0) ? 0 : $urandom_range(1, 24),
                   $urandom_range(0, 20), book.now_time + $urandom_range(0, 6));
  endfunction

  task automatic send_item(input in_t item);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    book.note_transaction(item);
    items_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (book.expected_ticks.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic set_miss_limit(input bit [1:0] limit);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= limit;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    book.miss_limit = limit;
  endtask

  task automatic run_phase(input int unsigned phase_end);
    int unsigned nticks;
    while (items_sent < phase_end) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(mk_noise());
      end else begin
        repeat ($urandom_range(1, 5)) send_item(mk_small_load());
        nticks = $urandom_range(8, 40);
        repeat (nticks) begin
          if ($urandom_range(0, 19) == 0) send_item(mk_small_load());
          else send_item(mk_tick());
        end
      end
    end
  endtask

  initial begin
    bit [1:0]    limits[NumPhases];
    int unsigned quota;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    calm        = 1'b0;
    items_sent  = 0;
    cycles      = 0;
    book        = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(mk_tick());
    send_item(mk_load(7, 4095, 4095, 4095, 16'hFFFF));
    send_item(mk_load(1, 0, 0, 0, 0));
    send_item(mk_load(2, 1, 3, 1, 0));
    send_item(mk_load(3, 3, 0, 0, 0));
    repeat (10) send_item(mk_tick());
    send_item(mk_load(0, 1, 1, 1, 0));
    repeat (4) send_item(mk_tick());
    send_item(mk_load(0, 2, 2, 4095, 16'hFFFF));
    repeat (3) send_item(mk_tick());

    limits = '{MissLimitReset, 2'd0, 2'd3, 2'd2, 2'($urandom), 2'($urandom)};
    quota  = (NumItems - items_sent) / NumPhases;
    for (int p = 0; p < NumPhases; p++) begin
      if (p != 0) set_miss_limit(limits[p]);
      if (p == NumPhases - 1) calm = 1'b1;
      run_phase(items_sent + quota);
    end

    drain();
    if (book.errors == 0 && book.expected_ticks.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
src/fpmk_pkg.sv
src/fpmk_window.sv
src/fixed_priority_mk_firm_scheduler.sv
verif/tb.sv
